// ----- rtl/core/line_rasterizer_assert.svh -----
// Assertion macros for the line rasterizer.
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define LR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line_rasterizer: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define LR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line_rasterizer: next-cycle check failed");

`endif

// ----- rtl/core/lr_pkg.sv -----
// Shared types, constants and helpers for the line rasterizer.
package lr_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int COLOR_BITS         = 16;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd3;

   typedef struct packed {
      logic       is_step;
      logic [1:0] dir_x;
      logic [1:0] dir_y;
   } cmd_ctl_type;

   typedef struct packed {
      logic active;
      logic emit;
      logic emit_last;
   } lr_status_type;

   // ctl, mag_x, mag_y, span, x0, y0, color
   function automatic int entry_bits(int coord_bits);
      return $bits(cmd_ctl_type) + 5 * coord_bits + COLOR_BITS;
   endfunction

endpackage

// ----- rtl/core/lr_front.sv -----
// Front end: accepts transactions and precomputes line setup.
module lr_front #(
   parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                       req_push,
   output logic                                       req_full,
   input  logic                                       req_kind,
   input  logic [COORD_BITS-1:0]                      req_x_start,
   input  logic [COORD_BITS-1:0]                      req_y_start,
   input  logic [COORD_BITS-1:0]                      req_x_end,
   input  logic [COORD_BITS-1:0]                      req_y_end,
   input  logic [lr_pkg::COLOR_BITS-1:0]              req_color,
   input  logic                                       q_full,
   output logic                                       q_push,
   output logic [lr_pkg::entry_bits(COORD_BITS)-1:0]  q_data
);
   import lr_pkg::*;

   cmd_ctl_type           ctl;
   logic [COORD_BITS-1:0] mag_x;
   logic [COORD_BITS-1:0] mag_y;
   logic [COORD_BITS-1:0] span;
   logic                  x_gt, x_lt, y_gt, y_lt;

   assign req_full = q_full;
   assign q_push   = req_push && !q_full;

   always_comb begin
      x_gt  = req_x_end > req_x_start;
      x_lt  = req_x_end < req_x_start;
      y_gt  = req_y_end > req_y_start;
      y_lt  = req_y_end < req_y_start;
      mag_x = x_gt ? (req_x_end - req_x_start) : (req_x_start - req_x_end);
      mag_y = y_gt ? (req_y_end - req_y_start) : (req_y_start - req_y_end);
      span  = (mag_x > mag_y) ? mag_x : mag_y;
      ctl.is_step = (req_kind == KIND_STEP);
      ctl.dir_x   = x_gt ? DIR_UP : (x_lt ? DIR_DOWN : DIR_NONE);
      ctl.dir_y   = y_gt ? DIR_UP : (y_lt ? DIR_DOWN : DIR_NONE);
   end

   assign q_data = {ctl, mag_x, mag_y, span, req_x_start, req_y_start, req_color};

endmodule

// ----- rtl/core/lr_fifo.sv -----
// Short command queue between the front and back ends.
module lr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = lr_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);
   import lr_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- rtl/core/lr_back.sv -----
// Back end: line state, error stepping and the pixel output register.
module lr_back #(
   parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       q_empty,
   input  logic [lr_pkg::entry_bits(COORD_BITS)-1:0]  q_data,
   output logic                                       q_pop,
   output logic                                       rsp_empty,
   input  logic                                       rsp_pop,
   output logic [COORD_BITS-1:0]                      rsp_pixel_x,
   output logic [COORD_BITS-1:0]                      rsp_pixel_y,
   output logic [lr_pkg::COLOR_BITS-1:0]              rsp_pixel_color,
   output logic                                       rsp_last,
   output lr_pkg::lr_status_type                      status
);
   import lr_pkg::*;

   localparam int C = COORD_BITS;

   cmd_ctl_type         h_ctl;
   logic [C-1:0]        h_mag_x, h_mag_y, h_span, h_x0, h_y0;
   logic [COLOR_BITS-1:0] h_color;

   logic [C-1:0]        cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [C:0]          err_x_ff, err_x_in, err_y_ff, err_y_in;
   logic [C-1:0]        mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic [1:0]          dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic [C-1:0]        span_ff, span_in;
   logic [C:0]          remaining_ff, remaining_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic                active_ff, active_in;

   logic                out_valid_ff, out_valid_in;
   logic [C-1:0]        out_x_ff, out_y_ff;
   logic [COLOR_BITS-1:0] out_color_ff;
   logic                out_last_ff;

   logic                out_free, emit, last_now;
   logic [C:0]          sum_x, sum_y, span_ext;
   logic                mv_x, mv_y;

   function automatic logic [C-1:0] axis_move(logic [C-1:0] c, logic [1:0] dir);
      logic [C-1:0] r;
      case (dir)
         DIR_UP:   r = c + C'(1);
         DIR_DOWN: r = c - C'(1);
         default:  r = c;
      endcase
      return r;
   endfunction

   assign {h_ctl, h_mag_x, h_mag_y, h_span, h_x0, h_y0, h_color} = q_data;

   assign out_free = !out_valid_ff || rsp_pop;
   assign emit     = !q_empty && h_ctl.is_step && active_ff && out_free;
   assign q_pop    = !q_empty && (!h_ctl.is_step || !active_ff || out_free);
   assign last_now = (remaining_ff <= (C+1)'(1));

   assign span_ext = {1'b0, span_ff};
   assign sum_x    = err_x_ff + {1'b0, mag_x_ff};
   assign sum_y    = err_y_ff + {1'b0, mag_y_ff};
   assign mv_x     = sum_x > span_ext;
   assign mv_y     = sum_y > span_ext;

   always_comb begin
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      err_x_in     = err_x_ff;
      err_y_in     = err_y_ff;
      mag_x_in     = mag_x_ff;
      mag_y_in     = mag_y_ff;
      dir_x_in     = dir_x_ff;
      dir_y_in     = dir_y_ff;
      span_in      = span_ff;
      remaining_in = remaining_ff;
      color_in     = color_ff;
      active_in    = active_ff;
      if (q_pop && !h_ctl.is_step) begin
         cur_x_in     = h_x0;
         cur_y_in     = h_y0;
         err_x_in     = '0;
         err_y_in     = '0;
         mag_x_in     = h_mag_x;
         mag_y_in     = h_mag_y;
         dir_x_in     = h_ctl.dir_x;
         dir_y_in     = h_ctl.dir_y;
         span_in      = h_span;
         remaining_in = {1'b0, h_span} + (C+1)'(1);
         color_in     = h_color;
         active_in    = 1'b1;
      end else if (emit) begin
         err_x_in = mv_x ? (sum_x - span_ext) : sum_x;
         err_y_in = mv_y ? (sum_y - span_ext) : sum_y;
         cur_x_in = mv_x ? axis_move(cur_x_ff, dir_x_ff) : cur_x_ff;
         cur_y_in = mv_y ? axis_move(cur_y_ff, dir_y_ff) : cur_y_ff;
         if (last_now) begin
            remaining_in = '0;
            active_in    = 1'b0;
         end else begin
            remaining_in = remaining_ff - (C+1)'(1);
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      err_x_ff     <= err_x_in;
      err_y_ff     <= err_y_in;
      mag_x_ff     <= mag_x_in;
      mag_y_ff     <= mag_y_in;
      dir_x_ff     <= dir_x_in;
      dir_y_ff     <= dir_y_in;
      span_ff      <= span_in;
      remaining_ff <= remaining_in;
      color_ff     <= color_in;
      if (emit) begin
         out_x_ff     <= cur_x_ff;
         out_y_ff     <= cur_y_ff;
         out_color_ff <= color_ff;
         out_last_ff  <= last_now;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_pixel_x     = out_x_ff;
   assign rsp_pixel_y     = out_y_ff;
   assign rsp_pixel_color = out_color_ff;
   assign rsp_last        = out_last_ff;

   assign status.active    = active_ff;
   assign status.emit      = emit;
   assign status.emit_last = emit && last_now;

endmodule

// ----- rtl/core/line_rasterizer.sv -----
// Line rasterizer top level: front end, command queue and back end.
//
// Input channel (req_*): push/full queue. A start transaction (kind 0)
// latches two endpoints and a color and emits nothing; a step transaction
// (kind 1) emits the next pixel of the active line, or nothing when idle.
// Result channel (rsp_*): empty/pop queue carrying x, y, color and last;
// last marks the final pixel of span+1 pixels.
// Throughput: one transaction per cycle while the receiver keeps up, set
// by the error update in the back end and its single output register,
// which reloads in the cycle it is popped.
// A step is written into the two-entry command queue, then leaves it into
// the output register, where its pixel shows.
// When the receiver stalls, the pixel holds, the back end stops on the
// next step, the queue fills and full rises two transactions later.
// Reset (synchronous) empties the queue, drops any line and marks the
// output register empty; no clearing pass is needed.
module line_rasterizer #(
   parameter int COORD_BITS = lr_pkg::COORD_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_kind,
   input  logic [COORD_BITS-1:0]         req_x_start,
   input  logic [COORD_BITS-1:0]         req_y_start,
   input  logic [COORD_BITS-1:0]         req_x_end,
   input  logic [COORD_BITS-1:0]         req_y_end,
   input  logic [lr_pkg::COLOR_BITS-1:0] req_color,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [COORD_BITS-1:0]         rsp_pixel_x,
   output logic [COORD_BITS-1:0]         rsp_pixel_y,
   output logic [lr_pkg::COLOR_BITS-1:0] rsp_pixel_color,
   output logic                          rsp_last
);
   import lr_pkg::*;

   localparam int ENTRY_BITS = entry_bits(COORD_BITS);

   logic                  q_push, q_pop, q_full, q_empty;
   logic [ENTRY_BITS-1:0] q_wr_data, q_rd_data;
   lr_status_type         status;

   lr_front #(.COORD_BITS(COORD_BITS)) u_front (
      .req_push    (req_push),
      .req_full    (req_full),
      .req_kind    (req_kind),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .req_color   (req_color),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_data      (q_wr_data)
   );

   lr_fifo #(.WIDTH(ENTRY_BITS), .DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .full    (q_full),
      .empty   (q_empty)
   );

   lr_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_data          (q_rd_data),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last),
      .status          (status)
   );

`include "line_rasterizer_assert.svh"

   `LR_ASSERT_SAME(a_pop_not_empty, clock, reset, q_pop, !q_empty)
   `LR_ASSERT_SAME(a_emit_needs_slot, clock, reset, status.emit, rsp_empty || rsp_pop)
   `LR_ASSERT_SAME(a_emit_when_active, clock, reset, status.emit, status.active && q_pop)
   `LR_ASSERT_NEXT(a_last_goes_idle, clock, reset, status.emit_last, !status.active)
   `LR_ASSERT_NEXT(a_emit_shows, clock, reset, status.emit, !rsp_empty)

endmodule
